@@ sv/scsr_pkg.sv @@
`default_nettype none

package scsr_pkg;

    localparam int FIELD_MODES    = 4;
    localparam int COORD_W        = 32;
    localparam int VALUE_W        = 64;
    localparam int ROW_W          = 33;
    localparam int POS_W          = 32;
    localparam int COL_W          = 64;
    localparam int MODE_W         = 2;
    localparam int NMODES_W       = 3;
    localparam int S_TDATA_W      = 192;
    localparam int M_TDATA_W      = 232;
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;

    localparam int DEF_MAX_MODES  = 4;
    localparam int DEF_INDEX_BITS = 32;
    localparam int DEF_QUEUE_DEPTH = 2;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_NUM_MODES   = 3'd0;
    localparam logic [2:0] REG_UNFOLD_MODE = 3'd1;
    localparam logic [2:0] REG_DIM_SIZE_0  = 3'd2;
    localparam logic [2:0] REG_DIM_SIZE_1  = 3'd3;
    localparam logic [2:0] REG_DIM_SIZE_2  = 3'd4;
    localparam logic [2:0] REG_DIM_SIZE_3  = 3'd5;

    localparam logic [NMODES_W-1:0] NUM_MODES_RST   = 3'd3;
    localparam logic [MODE_W-1:0]   UNFOLD_MODE_RST = 2'd0;
    localparam logic [COORD_W-1:0]  DIM_SIZE_RST    = 32'd1;

    // Result kinds carried on m_tuser.
    localparam logic KIND_FILL  = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    typedef struct packed {
        logic [NMODES_W-1:0]                num_modes;
        logic [MODE_W-1:0]                  unfold_mode;
        logic [FIELD_MODES-1:0][COORD_W-1:0] dim_size;
    } cfg_t;

    // One classified item as handed from the front to the back.
    typedef struct packed {
        logic                                has_fill;
        logic [ROW_W-1:0]                    fill_first;
        logic [ROW_W-1:0]                    fill_last;
        logic [POS_W-1:0]                    position;
        logic [FIELD_MODES-1:0][COORD_W-1:0] coord;
        logic [VALUE_W-1:0]                  value;
        logic                                has_trail;
        logic [ROW_W-1:0]                    trail_first;
        logic [ROW_W-1:0]                    trail_last;
        logic [POS_W-1:0]                    trail_pos;
    } cmd_t;

endpackage

`default_nettype wire

@@ sv/scsr_regs.sv @@
`default_nettype none

module scsr_regs #(
    parameter int INDEX_BITS = scsr_pkg::DEF_INDEX_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [scsr_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [scsr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [scsr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output scsr_pkg::cfg_t                         cfg
);

    scsr_pkg::cfg_t cfg_reg;
    logic [2:0]     idx;
    logic           wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.num_modes   <= scsr_pkg::NUM_MODES_RST;
            cfg_reg.unfold_mode <= scsr_pkg::UNFOLD_MODE_RST;
            for (int i = 0; i < scsr_pkg::FIELD_MODES; i++) begin
                cfg_reg.dim_size[i] <= scsr_pkg::DIM_SIZE_RST;
            end
        end else if (wr_en) begin
            case (idx)
                scsr_pkg::REG_NUM_MODES:   cfg_reg.num_modes   <= pwdata[2:0];
                scsr_pkg::REG_UNFOLD_MODE: cfg_reg.unfold_mode <= pwdata[1:0];
                scsr_pkg::REG_DIM_SIZE_0:  cfg_reg.dim_size[0] <= 32'(pwdata[INDEX_BITS-1:0]);
                scsr_pkg::REG_DIM_SIZE_1:  cfg_reg.dim_size[1] <= 32'(pwdata[INDEX_BITS-1:0]);
                scsr_pkg::REG_DIM_SIZE_2:  cfg_reg.dim_size[2] <= 32'(pwdata[INDEX_BITS-1:0]);
                scsr_pkg::REG_DIM_SIZE_3:  cfg_reg.dim_size[3] <= 32'(pwdata[INDEX_BITS-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            scsr_pkg::REG_NUM_MODES:   prdata = 32'(cfg_reg.num_modes);
            scsr_pkg::REG_UNFOLD_MODE: prdata = 32'(cfg_reg.unfold_mode);
            scsr_pkg::REG_DIM_SIZE_0:  prdata = cfg_reg.dim_size[0];
            scsr_pkg::REG_DIM_SIZE_1:  prdata = cfg_reg.dim_size[1];
            scsr_pkg::REG_DIM_SIZE_2:  prdata = cfg_reg.dim_size[2];
            scsr_pkg::REG_DIM_SIZE_3:  prdata = cfg_reg.dim_size[3];
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ sv/scsr_front.sv @@
`default_nettype none

module scsr_front #(
    parameter int INDEX_BITS = scsr_pkg::DEF_INDEX_BITS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire scsr_pkg::cfg_t                   cfg,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [scsr_pkg::S_TDATA_W-1:0]   in_data,
    input  wire logic                             in_last,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output scsr_pkg::cmd_t                        q_cmd
);

    localparam int IB = INDEX_BITS;

    logic [IB:0]   next_row_reg;
    logic [IB-1:0] count_reg;

    logic [scsr_pkg::FIELD_MODES-1:0][IB-1:0] coord_m;
    logic [IB:0]   row;
    logic [IB:0]   row_after;
    logic [IB:0]   nrows;
    logic [IB-1:0] count_after;
    logic          fill;
    logic          trail;

    always_comb begin
        for (int i = 0; i < scsr_pkg::FIELD_MODES; i++) begin
            coord_m[i] = in_data[i*scsr_pkg::COORD_W +: IB];
        end
    end

    assign row         = {1'b0, coord_m[cfg.unfold_mode]};
    assign fill        = (next_row_reg <= row);
    assign row_after   = fill ? (IB+1)'(row + 1'b1) : next_row_reg;
    assign count_after = count_reg + 1'b1;
    assign nrows       = {1'b0, cfg.dim_size[cfg.unfold_mode][IB-1:0]};
    // The closing fill only runs when it does not go backwards.
    assign trail       = in_last && (row_after <= nrows);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb begin
        q_cmd.has_fill    = fill;
        q_cmd.fill_first  = scsr_pkg::ROW_W'(next_row_reg);
        q_cmd.fill_last   = scsr_pkg::ROW_W'(row);
        q_cmd.position    = scsr_pkg::POS_W'(count_reg);
        for (int i = 0; i < scsr_pkg::FIELD_MODES; i++) begin
            q_cmd.coord[i] = scsr_pkg::COORD_W'(coord_m[i]);
        end
        q_cmd.value       = in_data[scsr_pkg::S_TDATA_W-1 -: scsr_pkg::VALUE_W];
        q_cmd.has_trail   = trail;
        q_cmd.trail_first = scsr_pkg::ROW_W'(row_after);
        q_cmd.trail_last  = scsr_pkg::ROW_W'(nrows);
        q_cmd.trail_pos   = scsr_pkg::POS_W'(count_after);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            next_row_reg <= '0;
            count_reg    <= '0;
        end else if (q_push) begin
            if (in_last) begin
                next_row_reg <= '0;
                count_reg    <= '0;
            end else begin
                next_row_reg <= row_after;
                count_reg    <= count_after;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/scsr_queue.sv @@
`default_nettype none

module scsr_queue #(
    parameter int DEPTH = scsr_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire scsr_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output scsr_pkg::cmd_t      pop_cmd,
    output logic                full,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    scsr_pkg::cmd_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign pop_cmd = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("item pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("item popped from an empty queue");

endmodule

`default_nettype wire

@@ sv/scsr_back.sv @@
`default_nettype none

module scsr_back #(
    parameter int MAX_MODES = scsr_pkg::DEF_MAX_MODES
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire scsr_pkg::cfg_t                   cfg,
    input  wire logic                             q_empty,
    input  wire scsr_pkg::cmd_t                   q_cmd,
    output logic                                  q_pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [scsr_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                  m_tuser,
    output logic                                  m_tlast
);

    localparam int LIM = (MAX_MODES < scsr_pkg::FIELD_MODES) ? MAX_MODES
                                                             : scsr_pkg::FIELD_MODES;
    localparam logic [scsr_pkg::NMODES_W-1:0] LIM_NM = scsr_pkg::NMODES_W'(LIM);
    localparam int PAD_W = scsr_pkg::M_TDATA_W - 2*scsr_pkg::ROW_W - scsr_pkg::POS_W
                           - scsr_pkg::COL_W - scsr_pkg::VALUE_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_C_LO,
        S_C_HI,
        S_D_LO,
        S_D_HI,
        S_D_SUM,
        S_ENTRY,
        S_TRAIL
    } state_t;

    state_t                        state_reg;
    scsr_pkg::cmd_t                cmd_reg;
    logic [scsr_pkg::MODE_W-1:0]   off_reg;
    logic [scsr_pkg::COL_W-1:0]    col_reg;
    logic [scsr_pkg::COL_W-1:0]    mult_reg;
    logic [scsr_pkg::COL_W-1:0]    mult_part_reg;
    logic [63:0]                   prod_reg;
    logic                          m_tvalid_reg;
    logic [scsr_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                          m_tuser_reg;
    logic                          m_tlast_reg;

    logic [scsr_pkg::NMODES_W-1:0] nm;
    logic [31:0]                   mul_a;
    logic [31:0]                   mul_b;
    logic                          out_free;
    logic                          emit;
    logic                          skip_mode;
    logic [scsr_pkg::COORD_W-1:0]  cur_coord;
    logic [scsr_pkg::COORD_W-1:0]  cur_dim;

    // Out-of-range mode counts fold into the supported range.
    always_comb begin
        if (cfg.num_modes == '0) begin
            nm = scsr_pkg::NMODES_W'(1);
        end else if (cfg.num_modes > LIM_NM) begin
            nm = LIM_NM;
        end else begin
            nm = cfg.num_modes;
        end
    end

    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit      = out_free && ((state_reg == S_FILL) || (state_reg == S_ENTRY)
                                    || (state_reg == S_TRAIL));
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign skip_mode = (off_reg == cfg.unfold_mode);
    assign cur_coord = cmd_reg.coord[off_reg];
    assign cur_dim   = cfg.dim_size[off_reg];

    // One shared 32x32 multiplier; the 64-bit products mod 2^64 are built
    // from a low-half product and a high-half product shifted up.
    always_comb begin
        unique case (state_reg)
            S_C_LO:  begin mul_a = cur_coord;       mul_b = mult_reg[31:0];  end
            S_C_HI:  begin mul_a = cur_coord;       mul_b = mult_reg[63:32]; end
            S_D_LO:  begin mul_a = mult_reg[31:0];  mul_b = cur_dim;         end
            S_D_HI:  begin mul_a = mult_reg[63:32]; mul_b = cur_dim;         end
            default: begin mul_a = '0;              mul_b = '0;              end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        cmd_reg   <= q_cmd;
                        col_reg   <= '0;
                        mult_reg  <= 64'd1;
                        off_reg   <= scsr_pkg::MODE_W'(nm - 1'b1);
                        state_reg <= q_cmd.has_fill ? S_FILL : S_C_LO;
                    end
                end
                S_FILL: begin
                    if (out_free) begin
                        m_tuser_reg  <= scsr_pkg::KIND_FILL;
                        m_tlast_reg  <= 1'b0;
                        m_tdata_reg  <= {PAD_W'(0), 64'd0, 64'd0, cmd_reg.position,
                                         cmd_reg.fill_last, cmd_reg.fill_first};
                        state_reg    <= S_C_LO;
                    end
                end
                S_C_LO: begin
                    if (skip_mode) begin
                        if (off_reg == '0) begin
                            state_reg <= S_ENTRY;
                        end else begin
                            off_reg <= off_reg - 1'b1;
                        end
                    end else begin
                        state_reg <= S_C_HI;
                    end
                end
                S_C_HI: begin
                    col_reg   <= col_reg + prod_reg;
                    state_reg <= S_D_LO;
                end
                S_D_LO: begin
                    col_reg   <= col_reg + {prod_reg[31:0], 32'd0};
                    state_reg <= S_D_HI;
                end
                S_D_HI: begin
                    mult_part_reg <= prod_reg;
                    state_reg     <= S_D_SUM;
                end
                S_D_SUM: begin
                    mult_reg <= mult_part_reg + {prod_reg[31:0], 32'd0};
                    if (off_reg == '0) begin
                        state_reg <= S_ENTRY;
                    end else begin
                        off_reg   <= off_reg - 1'b1;
                        state_reg <= S_C_LO;
                    end
                end
                S_ENTRY: begin
                    if (out_free) begin
                        m_tuser_reg  <= scsr_pkg::KIND_ENTRY;
                        m_tlast_reg  <= !cmd_reg.has_trail;
                        m_tdata_reg  <= {PAD_W'(0), cmd_reg.value, col_reg, cmd_reg.position,
                                         33'd0, 33'd0};
                        state_reg    <= cmd_reg.has_trail ? S_TRAIL : S_IDLE;
                    end
                end
                S_TRAIL: begin
                    if (out_free) begin
                        m_tuser_reg  <= scsr_pkg::KIND_FILL;
                        m_tlast_reg  <= 1'b1;
                        m_tdata_reg  <= {PAD_W'(0), 64'd0, 64'd0, cmd_reg.trail_pos,
                                         cmd_reg.trail_last, cmd_reg.trail_first};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_entry_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ENTRY && out_free) |=>
            (m_tvalid && m_tuser == scsr_pkg::KIND_ENTRY))
        else $error("entry result not presented after column math");

    a_trail_only_when_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TRAIL) |-> cmd_reg.has_trail)
        else $error("closing fill started for an item that is not the last");

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == scsr_pkg::KIND_FILL) |->
            (m_tdata[32:0] <= m_tdata[65:33]))
        else $error("fill result with first row above last row");

    a_pop_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg != S_IDLE))
        else $error("item taken from queue but back end stayed idle");

endmodule

`default_nettype wire

@@ sv/sorted_coo_to_csr_unfold.sv @@
// Streaming COO-to-CSR unfolder. Nonzeros arrive on the s_ side sorted by the
// unfold mode; for each item the block gives an optional row-pointer fill, the
// matrix entry with its mixed-radix column index, and on the last item an
// optional closing fill, each on the m_ side with m_tuser telling fill from
// entry and m_tlast marking the last result of an item. A front stage
// classifies items and keeps the row and entry counters, so it accepts a new
// item whenever the item queue (QUEUE_DEPTH deep, two by default) has room. The
// back end picks up an item, works out the column index over the in-use modes
// other than the unfold mode (one shared 32x32 multiplier, four products per
// mode), then emits each result, waiting while a result is held by a low
// m_tready; it takes the next item only once the current one is emitted.
// Configuration registers must be written through the APB port only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

module sorted_coo_to_csr_unfold #(
    parameter int MAX_MODES   = scsr_pkg::DEF_MAX_MODES,
    parameter int INDEX_BITS  = scsr_pkg::DEF_INDEX_BITS,
    parameter int QUEUE_DEPTH = scsr_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [scsr_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [scsr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [scsr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // coord_0 [31:0], coord_1 [63:32], coord_2 [95:64], coord_3 [127:96],
    // entry_value [191:128]
    input  wire logic [scsr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // fill_first_row [32:0], fill_last_row [65:33], position [97:66],
    // column_index [161:98], out_value [225:162], zero [231:226]
    output logic      [scsr_pkg::M_TDATA_W-1:0]   m_tdata,
    // result_kind [0]
    output logic                                  m_tuser,
    output logic                                  m_tlast
);

    scsr_pkg::cfg_t cfg;
    scsr_pkg::cmd_t push_cmd;
    scsr_pkg::cmd_t pop_cmd;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    scsr_regs #(
        .INDEX_BITS (INDEX_BITS)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    scsr_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata),
        .in_last  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    scsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    scsr_back #(
        .MAX_MODES (MAX_MODES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

typedef logic [scsr_pkg::FIELD_MODES-1:0][scsr_pkg::COORD_W-1:0] coord_set_t;

typedef struct packed {
    logic                         kind;
    logic [scsr_pkg::ROW_W-1:0]   first_row;
    logic [scsr_pkg::ROW_W-1:0]   last_row;
    logic [scsr_pkg::POS_W-1:0]   position;
    logic [scsr_pkg::COL_W-1:0]   column;
    logic [scsr_pkg::VALUE_W-1:0] value;
    logic                         run_last;
} csr_result_t;

class csr_unfold_checker;
    logic [scsr_pkg::NMODES_W-1:0] num_modes;
    logic [scsr_pkg::MODE_W-1:0]   unfold_mode;
    coord_set_t                    dim_size;
    logic [scsr_pkg::ROW_W-1:0]    next_row;
    logic [scsr_pkg::POS_W-1:0]    entry_count;
    csr_result_t                   awaited_results[$];
    int                            mismatches;

    function new();
        num_modes   = scsr_pkg::NUM_MODES_RST;
        unfold_mode = scsr_pkg::UNFOLD_MODE_RST;
        for (int i = 0; i < scsr_pkg::FIELD_MODES; i++) dim_size[i] = scsr_pkg::DIM_SIZE_RST;
        next_row    = '0;
        entry_count = '0;
        mismatches  = 0;
    endfunction

    function void write_reg(logic [2:0] index, logic [scsr_pkg::APB_DATA_W-1:0] data);
        case (index)
            scsr_pkg::REG_NUM_MODES:   num_modes = data[scsr_pkg::NMODES_W-1:0];
            scsr_pkg::REG_UNFOLD_MODE: unfold_mode = data[scsr_pkg::MODE_W-1:0];
            scsr_pkg::REG_DIM_SIZE_0:  dim_size[0] = data;
            scsr_pkg::REG_DIM_SIZE_1:  dim_size[1] = data;
            scsr_pkg::REG_DIM_SIZE_2:  dim_size[2] = data;
            scsr_pkg::REG_DIM_SIZE_3:  dim_size[3] = data;
            default: ;
        endcase
    endfunction

    function void queue_result(logic kind, logic [scsr_pkg::ROW_W-1:0] first_row,
                               logic [scsr_pkg::ROW_W-1:0] last_row,
                               logic [scsr_pkg::POS_W-1:0] position,
                               logic [scsr_pkg::COL_W-1:0] column,
                               logic [scsr_pkg::VALUE_W-1:0] value,
                               logic run_last);
        csr_result_t r;
        r.kind      = kind;
        r.first_row = first_row;
        r.last_row  = last_row;
        r.position  = position;
        r.column    = column;
        r.value     = value;
        r.run_last  = run_last;
        awaited_results.push_back(r);
    endfunction

    // Works out the fill, the entry and the closing fill caused by one nonzero.
    function void predict_nonzero(coord_set_t coord, logic [scsr_pkg::VALUE_W-1:0] value,
                                  logic closing);
        int                         limit;
        int                         modes;
        int                         off;
        logic [scsr_pkg::ROW_W-1:0] row;
        logic [scsr_pkg::ROW_W-1:0] row_after;
        logic [scsr_pkg::ROW_W-1:0] nrows;
        logic [scsr_pkg::COL_W-1:0] column;
        logic [scsr_pkg::COL_W-1:0] radix;
        logic                       has_fill;
        logic                       has_trail;

        limit = (scsr_pkg::DEF_MAX_MODES < scsr_pkg::FIELD_MODES) ? scsr_pkg::DEF_MAX_MODES
                                                                   : scsr_pkg::FIELD_MODES;
        modes = int'(num_modes);
        if (modes < 1) modes = 1;
        if (modes > limit) modes = limit;

        row       = {1'b0, coord[unfold_mode]};
        has_fill  = (next_row <= row);
        row_after = has_fill ? row + 1'b1 : next_row;
        nrows     = {1'b0, dim_size[unfold_mode]};
        has_trail = closing && (row_after <= nrows);

        // The highest in-use mode varies fastest in the column index.
        column = '0;
        radix  = 64'd1;
        for (int m = 0; m < modes; m++) begin
            off = modes - 1 - m;
            if (off != int'(unfold_mode)) begin
                column = column + 64'(coord[off]) * radix;
                radix  = radix * 64'(dim_size[off]);
            end
        end

        if (has_fill) begin
            queue_result(scsr_pkg::KIND_FILL, next_row, row, entry_count, '0, '0, 1'b0);
        end
        queue_result(scsr_pkg::KIND_ENTRY, '0, '0, entry_count, column, value, !has_trail);
        next_row    = row_after;
        entry_count = entry_count + 1'b1;

        if (closing) begin
            if (has_trail) begin
                queue_result(scsr_pkg::KIND_FILL, next_row, nrows, entry_count, '0, '0, 1'b1);
            end
            next_row    = '0;
            entry_count = '0;
        end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function void check_result(logic [scsr_pkg::M_TDATA_W-1:0] tdata, logic tuser,
                               logic tlast);
        csr_result_t want;
        if (awaited_results.size() == 0) begin
            $display("%0t: result with none expected, expected nothing actual kind %0d tdata %h",
                     $time, tuser, tdata);
            mismatches++;
            return;
        end
        want = awaited_results.pop_front();
        compare_field("result_kind", 64'(want.kind), 64'(tuser));
        compare_field("fill_first_row", 64'(want.first_row), 64'(tdata[32:0]));
        compare_field("fill_last_row", 64'(want.last_row), 64'(tdata[65:33]));
        compare_field("position", 64'(want.position), 64'(tdata[97:66]));
        compare_field("column_index", want.column, tdata[161:98]);
        compare_field("out_value", want.value, tdata[225:162]);
        compare_field("tdata padding", 64'd0, 64'(tdata[231:226]));
        compare_field("run_last", 64'(want.run_last), 64'(tlast));
    endfunction

    function int pending();
        return awaited_results.size();
    endfunction
endclass

module testbench;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_STOP  = 300;

    logic                            aclk;
    logic                            aresetn;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [scsr_pkg::APB_ADDR_W-1:0] paddr;
    logic [scsr_pkg::APB_DATA_W-1:0] pwdata;
    logic [scsr_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [scsr_pkg::S_TDATA_W-1:0]  s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [scsr_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    csr_unfold_checker           csr_model = new();
    int                          nonzeros_accepted = 0;
    bit                          hold_done = 1'b0;
    logic [scsr_pkg::MODE_W-1:0] cfg_mode = scsr_pkg::UNFOLD_MODE_RST;
    coord_set_t                  cfg_dim = {scsr_pkg::FIELD_MODES{scsr_pkg::DIM_SIZE_RST}};

    sorted_coo_to_csr_unfold dut (.*);

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic coord_set_t coords(logic [31:0] c0, logic [31:0] c1,
                                          logic [31:0] c2, logic [31:0] c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic logic [31:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 32'd0;
        if (r < 16) return 32'd1;
        if (r < 22) return 32'hFFFF_FFFF;
        if (r < 30) return $urandom;
        return $urandom_range(2, 40);
    endfunction

    task automatic apb_write(logic [2:0] index, logic [scsr_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        csr_model.write_reg(index, data);
        @(posedge aclk);
    endtask

    task automatic set_config(logic [2:0] modes, logic [1:0] mode, logic [31:0] d0,
                              logic [31:0] d1, logic [31:0] d2, logic [31:0] d3);
        apb_write(scsr_pkg::REG_NUM_MODES, {29'd0, modes});
        apb_write(scsr_pkg::REG_UNFOLD_MODE, {30'd0, mode});
        apb_write(scsr_pkg::REG_DIM_SIZE_0, d0);
        apb_write(scsr_pkg::REG_DIM_SIZE_1, d1);
        apb_write(scsr_pkg::REG_DIM_SIZE_2, d2);
        apb_write(scsr_pkg::REG_DIM_SIZE_3, d3);
        cfg_mode = mode;
        cfg_dim  = {d3, d2, d1, d0};
    endtask

    task automatic send_nonzero(coord_set_t coord, logic [scsr_pkg::VALUE_W-1:0] value,
                                logic closing);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (r < 55) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, coord};
        s_tlast  <= closing;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        csr_model.predict_nonzero(coord, value, closing);
        nonzeros_accepted++;
    endtask

    // Mostly sorted rows with random content; a few rows step back to
    // exercise the already-opened row case.
    task automatic run_tensor(int count, bit closed);
        coord_set_t  coord;
        logic [31:0] row;
        logic [31:0] row_now;
        int          r;
        row = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8 && row > 0) begin
                row_now = $urandom_range(0, row - 1);
            end else begin
                if (r >= 90) row = row + $urandom_range(2, 6);
                else if (r >= 50) row = row + 1;
                row_now = row;
            end
            for (int m = 0; m < scsr_pkg::FIELD_MODES; m++) begin
                if (m == int'(cfg_mode)) coord[m] = row_now;
                else if (cfg_dim[m] == 0 || $urandom_range(0, 9) == 0) coord[m] = $urandom;
                else coord[m] = $urandom_range(0, cfg_dim[m] - 1);
            end
            send_nonzero(coord, {$urandom, $urandom}, closed && (i == count - 1));
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (csr_model.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) csr_model.check_result(m_tdata, m_tuser, m_tlast);
    end

    initial begin : result_sink
        int r;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (!hold_done && nonzeros_accepted >= 90) begin
                // Long hold-off so the block fills up and backs up its input.
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                m_tready <= 1'b1;
                if (r < 15) begin
                    repeat ($urandom_range(40, 120)) @(posedge aclk);
                end else begin
                    repeat ($urandom_range(1, 6)) @(posedge aclk);
                    m_tready <= 1'b0;
                    if (r < 90) repeat ($urandom_range(1, 3)) @(posedge aclk);
                    else repeat ($urandom_range(15, 50)) @(posedge aclk);
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        int          r;
        logic [2:0]  modes;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        aresetn  = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Settings after reset: three modes, rows from mode 0, unit extents.
        send_nonzero(coords(0, 0, 0, 0), 64'd0, 1'b0);
        send_nonzero(coords(0, '1, '1, '1), '1, 1'b0);
        send_nonzero(coords(5, 1, 2, 3), 64'h0123_4567_89AB_CDEF, 1'b1);
        send_nonzero(coords(0, 0, 0, 0), 64'h8000_0000_0000_0001, 1'b1);
        drain_results();

        // Four modes, rows from mode 1, one row steps back before the close.
        set_config(3'd4, 2'd1, 32'd10, 32'd20, 32'd30, 32'd40);
        send_nonzero(coords(3, 0, 5, 7), {$urandom, $urandom}, 1'b0);
        send_nonzero(coords(9, 0, 29, 39), {$urandom, $urandom}, 1'b0);
        send_nonzero(coords(1, 4, 2, 3), {$urandom, $urandom}, 1'b0);
        send_nonzero(coords(2, 2, 0, 0), {$urandom, $urandom}, 1'b0);
        send_nonzero(coords(0, 19, 0, 0), {$urandom, $urandom}, 1'b1);
        drain_results();

        // Zero mode count acts as one; zero extent on the row mode; top row.
        set_config(3'd0, 2'd0, 32'd0, 32'd5, 32'd5, 32'd5);
        send_nonzero(coords('1, 1, 2, 3), {$urandom, $urandom}, 1'b0);
        send_nonzero(coords('1, 4, 4, 4), {$urandom, $urandom}, 1'b0);
        send_nonzero(coords(7, 0, 0, 0), {$urandom, $urandom}, 1'b1);
        drain_results();

        // Mode count above the limit, rows from mode 3, largest extents.
        set_config(3'd7, 2'd3, '1, '1, '1, '1);
        send_nonzero(coords('1, '1, '1, 0), {$urandom, $urandom}, 1'b0);
        send_nonzero(coords(123, 456, 789, 32'h10), {$urandom, $urandom}, 1'b0);
        send_nonzero(coords('1, '1, '1, '1), {$urandom, $urandom}, 1'b1);
        drain_results();

        // Unfold mode outside the two in-use modes, with a zero radix.
        set_config(3'd2, 2'd2, 32'd3, 32'd0, 32'd6, 32'd1);
        send_nonzero(coords(2, 9, 0, 0), {$urandom, $urandom}, 1'b0);
        send_nonzero(coords(1, 3, 4, 0), {$urandom, $urandom}, 1'b0);
        send_nonzero(coords(0, 0, 5, 0), {$urandom, $urandom}, 1'b1);
        drain_results();

        set_config(3'd5, 2'd3, 32'd2, 32'd3, 32'd4, 32'd0);
        send_nonzero(coords(1, 2, 3, 0), {$urandom, $urandom}, 1'b0);
        send_nonzero(coords(1, 1, 1, 0), {$urandom, $urandom}, 1'b1);
        drain_results();

        while (nonzeros_accepted < RANDOM_STOP) begin
            r = $urandom_range(0, 99);
            if (r < 10) modes = 3'd0;
            else if (r < 20) modes = 3'($urandom_range(5, 7));
            else modes = 3'($urandom_range(1, 4));
            set_config(modes, 2'($urandom_range(0, 3)), pick_dim(), pick_dim(), pick_dim(),
                       pick_dim());
            repeat ($urandom_range(1, 3)) run_tensor($urandom_range(1, 16),
                                                     $urandom_range(0, 9) != 0);
            drain_results();
        end

        if (csr_model.mismatches == 0 && csr_model.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
sv/scsr_pkg.sv
sv/scsr_regs.sv
sv/scsr_front.sv
sv/scsr_queue.sv
sv/scsr_back.sv
sv/sorted_coo_to_csr_unfold.sv
sim/testbench.sv
